/* sv/esd_pkg.sv */
package esd_pkg;

	// Accumulator width; the decoded value wraps modulo 2^VALUE_WIDTH
	localparam int unsigned VALUE_WIDTH = 32;
	localparam int unsigned CH_W        = 21;
	localparam int unsigned CP_W        = 32;
	localparam int unsigned CNT_W       = 4;

	// Digit counts of the fixed-length forms and the octal digit limit
	localparam logic [CNT_W-1:0] OCT_MAX_DIGITS = CNT_W'(3);
	localparam logic [CNT_W-1:0] USHORT_DIGITS  = CNT_W'(4);
	localparam logic [CNT_W-1:0] ULONG_DIGITS   = CNT_W'(8);

	// Characters with a role in the grammar
	localparam logic [CH_W-1:0] CH_LBRACE = CH_W'(8'h7B);
	localparam logic [CH_W-1:0] CH_RBRACE = CH_W'(8'h7D);
	localparam logic [CH_W-1:0] CH_LOW_O  = CH_W'(8'h6F);
	localparam logic [CH_W-1:0] CH_LOW_X  = CH_W'(8'h78);
	localparam logic [CH_W-1:0] CH_LOW_U  = CH_W'(8'h75);
	localparam logic [CH_W-1:0] CH_UP_U   = CH_W'(8'h55);
	localparam logic [CH_W-1:0] CH_ZERO   = CH_W'(8'h30);
	localparam logic [CH_W-1:0] CH_SEVEN  = CH_W'(8'h37);
	localparam logic [CH_W-1:0] CH_NINE   = CH_W'(8'h39);
	localparam logic [CH_W-1:0] CH_LOW_A  = CH_W'(8'h61);
	localparam logic [CH_W-1:0] CH_LOW_F  = CH_W'(8'h66);
	localparam logic [CH_W-1:0] CH_UP_A   = CH_W'(8'h41);
	localparam logic [CH_W-1:0] CH_UP_F   = CH_W'(8'h46);

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_OCT    = 4'd1,
		M_OOPEN  = 4'd2,
		M_OBRACE = 4'd3,
		M_XFIRST = 4'd4,
		M_XRUN   = 4'd5,
		M_XBRACE = 4'd6,
		M_UFIRST = 4'd7,
		M_UBRACE = 4'd8,
		M_USHORT = 4'd9,
		M_ULONG  = 4'd10
	} esd_mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNKNOWN = 3'd1,
		ST_BRACE   = 3'd2,
		ST_DIGIT   = 3'd3,
		ST_EMPTY   = 3'd4
	} esd_status_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            first_after_slash;
	} esd_in_t;

	typedef struct packed {
		logic            done_res;
		logic            consumed;
		logic [CP_W-1:0] code_point;
		logic [2:0]      status;
	} esd_out_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] val;
	} esd_simple_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} esd_hex_t;

	// Map a simple escape letter to its byte value
	function automatic esd_simple_t simple_escape(input logic [CH_W-1:0] c);
		esd_simple_t r;
		r.hit = 1'b1;
		r.val = 8'h00;
		if (c[CH_W-1:8] != '0) begin
			r.hit = 1'b0;
		end else begin
			unique case (c[7:0])
				8'h27: r.val = 8'h27;
				8'h22: r.val = 8'h22;
				8'h3F: r.val = 8'h3F;
				8'h5C: r.val = 8'h5C;
				8'h61: r.val = 8'h07;
				8'h62: r.val = 8'h08;
				8'h66: r.val = 8'h0C;
				8'h6E: r.val = 8'h0A;
				8'h72: r.val = 8'h0D;
				8'h74: r.val = 8'h09;
				8'h76: r.val = 8'h0B;
				8'h65: r.val = 8'h1B;
				default: r.hit = 1'b0;
			endcase
		end
		return r;
	endfunction

	// ASCII hex digit to nibble
	function automatic esd_hex_t hex_digit(input logic [CH_W-1:0] c);
		esd_hex_t r;
		r.ok  = 1'b1;
		r.val = 4'h0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r.val = c[3:0];
		end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
			r.val = 4'(c[3:0] + 4'd9);
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			r.val = 4'(c[3:0] + 4'd9);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

/* sv/esd_stream_if.sv */
interface esd_in_if;
	import esd_pkg::*;

	logic    valid;
	logic    ready;
	esd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface esd_out_if;
	import esd_pkg::*;

	logic     valid;
	logic     ready;
	esd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/escape_sequence_decoder.sv */
// Channel   Dir  Payload                                    Beat when
// chars     in   ch[20:0], first_after_slash               valid & ready
// results   out  done_res, consumed, code_point[31:0],     valid & ready
//                status[2:0]
//
// Each character beat yields one result beat: it waits in the input register,
// then its decode goes into the result register. One beat per cycle sustained
// while results is ready; the decode step (compare, shift-and-or of the
// accumulator) sits between the input register and the result register.
// arst_n clears both valid flags and returns the decoder to idle.
// A stall on results holds both stages; chars stays ready while a stage is free.
module escape_sequence_decoder
	import esd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	esd_in_if.sink    chars,
	esd_out_if.source results
);

	logic                   valid_s1;
	esd_in_t                item_s1;
	logic                   out_valid_q;
	esd_out_t               out_data_q;

	esd_mode_t              mode_q,  mode_d;
	logic [VALUE_WIDTH-1:0] acc_q,   acc_d;
	logic [CNT_W-1:0]       cnt_q,   cnt_d;
	logic                   seen_q,  seen_d;
	esd_out_t               res;

	logic                   adv_s1;
	logic                   take_in;

	// Advance when the result register is free or being drained
	assign adv_s1  = !out_valid_q || results.ready;
	assign chars.ready = !valid_s1 || adv_s1;
	assign take_in = chars.valid && chars.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= chars.data;
		end
	end

	// Decode one character against the current state
	logic [CH_W-1:0]        c;
	logic                   is_oct;
	esd_hex_t               hx;
	esd_simple_t            se;
	logic [VALUE_WIDTH-1:0] acc_oct;
	logic [VALUE_WIDTH-1:0] acc_hex;
	logic [CNT_W-1:0]       cnt_inc;

	assign c       = item_s1.ch;
	assign is_oct  = (c >= CH_ZERO) && (c <= CH_SEVEN);
	assign hx      = hex_digit(c);
	assign se      = simple_escape(c);
	assign acc_oct = {acc_q[VALUE_WIDTH-4:0], c[2:0]};
	assign acc_hex = {acc_q[VALUE_WIDTH-5:0], hx.val};
	assign cnt_inc = CNT_W'(cnt_q + CNT_W'(1));

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		seen_d = seen_q;
		res.done_res   = 1'b0;
		res.consumed   = 1'b1;
		res.code_point = '0;
		res.status     = ST_OK;

		if (item_s1.first_after_slash) begin
			// Start a new sequence, dropping any open one
			mode_d = M_IDLE;
			acc_d  = '0;
			cnt_d  = '0;
			seen_d = 1'b0;
			if (se.hit) begin
				res.done_res   = 1'b1;
				res.code_point = CP_W'(se.val);
			end else if (c == CH_LOW_O) begin
				mode_d = M_OOPEN;
			end else if (c == CH_LOW_X) begin
				mode_d = M_XFIRST;
			end else if (c == CH_LOW_U) begin
				mode_d = M_UFIRST;
			end else if (c == CH_UP_U) begin
				mode_d = M_ULONG;
			end else if (is_oct) begin
				acc_d  = VALUE_WIDTH'(c[2:0]);
				cnt_d  = CNT_W'(1);
				mode_d = M_OCT;
			end else begin
				res.done_res = 1'b1;
				res.status   = ST_UNKNOWN;
			end
		end else begin
			unique case (mode_q)
				M_OCT: begin
					if (!is_oct) begin
						res.done_res = 1'b1;
						res.consumed = 1'b0;
						res.code_point = CP_W'(acc_q);
					end else begin
						acc_d = acc_oct;
						cnt_d = cnt_inc;
						if (cnt_inc >= OCT_MAX_DIGITS) begin
							res.done_res   = 1'b1;
							res.code_point = CP_W'(acc_oct);
						end
					end
				end
				M_OOPEN: begin
					if (c != CH_LBRACE) begin
						res.done_res = 1'b1;
						res.status   = ST_BRACE;
					end else begin
						mode_d = M_OBRACE;
					end
				end
				M_OBRACE: begin
					if (c == CH_RBRACE) begin
						res.done_res = 1'b1;
						if (seen_q) begin
							res.code_point = CP_W'(acc_q);
						end else begin
							res.status = ST_EMPTY;
						end
					end else if (!is_oct || cnt_q >= OCT_MAX_DIGITS) begin
						res.done_res = 1'b1;
						res.status   = ST_DIGIT;
					end else begin
						acc_d  = acc_oct;
						cnt_d  = cnt_inc;
						seen_d = 1'b1;
					end
				end
				M_XFIRST: begin
					if (c == CH_LBRACE) begin
						mode_d = M_XBRACE;
					end else if (!hx.ok) begin
						res.done_res = 1'b1;
						res.consumed = 1'b0;
						res.status   = ST_DIGIT;
					end else begin
						acc_d  = acc_hex;
						mode_d = M_XRUN;
					end
				end
				M_XRUN: begin
					if (!hx.ok) begin
						res.done_res   = 1'b1;
						res.consumed   = 1'b0;
						res.code_point = CP_W'(acc_q);
					end else begin
						acc_d = acc_hex;
					end
				end
				M_XBRACE, M_UBRACE: begin
					if (c == CH_RBRACE) begin
						res.done_res = 1'b1;
						if (seen_q) begin
							res.code_point = CP_W'(acc_q);
						end else begin
							res.status = ST_EMPTY;
						end
					end else if (!hx.ok) begin
						res.done_res = 1'b1;
						res.status   = ST_DIGIT;
					end else begin
						acc_d  = acc_hex;
						seen_d = 1'b1;
					end
				end
				M_UFIRST: begin
					if (c == CH_LBRACE) begin
						mode_d = M_UBRACE;
					end else if (!hx.ok) begin
						res.done_res = 1'b1;
						res.status   = ST_DIGIT;
					end else begin
						acc_d  = acc_hex;
						cnt_d  = CNT_W'(1);
						mode_d = M_USHORT;
					end
				end
				M_USHORT, M_ULONG: begin
					if (!hx.ok) begin
						res.done_res = 1'b1;
						res.status   = ST_DIGIT;
					end else begin
						acc_d = acc_hex;
						cnt_d = cnt_inc;
						if (cnt_inc >= ((mode_q == M_USHORT) ? USHORT_DIGITS : ULONG_DIGITS))
						begin
							res.done_res   = 1'b1;
							res.code_point = CP_W'(acc_hex);
						end
					end
				end
				default: begin
					// Character outside a sequence: refuse, keep state
					res.done_res = 1'b1;
					res.consumed = 1'b0;
					res.status   = ST_UNKNOWN;
				end
			endcase
		end

		// Drop the sequence once it finishes or fails
		if (res.done_res) begin
			mode_d = M_IDLE;
			acc_d  = '0;
			cnt_d  = '0;
			seen_d = 1'b0;
		end
	end

	// Decoder state advances with each beat leaving stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= '0;
			cnt_q  <= '0;
			seen_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			seen_q <= seen_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			out_data_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	// Idle always means a cleared accumulator and counters
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_IDLE |-> (acc_q == '0 && cnt_q == '0 && !seen_q))
		else $error("idle with live accumulator state");

	// Digit counter never passes the longest fixed form
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ULONG_DIGITS)
		else $error("digit counter out of range");

	// A refused character always ends the sequence
	a_unconsumed_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.consumed |-> out_data_q.done_res)
		else $error("unconsumed character without done");

	// Errors carry done and a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status != ST_OK |->
			(out_data_q.done_res && out_data_q.code_point == '0))
		else $error("error result with value or without done");

	// A beat leaving stage one lands in the result register
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 |=> out_valid_q)
		else $error("stage one beat lost");

endmodule
